/* hw/rtl/mecb_pkg.sv */
// ----------------------------------------------------------------------------
// mecb_pkg
// Shared types, codes and helpers for the blossom matching / edge cover core.
// ----------------------------------------------------------------------------
package mecb_pkg;

  localparam int NV = 64;

  localparam logic [6:0] NONE_V    = 7'd64;
  localparam logic [6:0] VC_RESET  = 7'd64;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_RUN = 2'd1;
  localparam logic [1:0] CMD_CLR = 2'd2;

  localparam logic [2:0] ADDR_VCOUNT = 3'd0;

  typedef enum logic [5:0] {
    ST_CLR, ST_IDLE, ST_ADD_RA, ST_ADD_WA, ST_ADD_WB,
    ST_RUN_INIT, ST_ROOT, ST_ROOT_W, ST_SINIT, ST_QCHK, ST_QW, ST_VW,
    ST_UCHK, ST_UW1, ST_UW2, ST_UW3,
    ST_CBA_R, ST_CBA_B, ST_CBA_C, ST_CBA_D,
    ST_CBB_SETUP, ST_CBB_R, ST_CBB_B, ST_CBB_C, ST_CBB_D,
    ST_MC_SETUP, ST_MC_R, ST_MC_B, ST_MC_C, ST_MC_D, ST_MC_E, ST_MC_NEXT,
    ST_CT_R, ST_CT_B,
    ST_AU_R, ST_AU_B, ST_AU_C, ST_AU_D, ST_AU_END,
    ST_E1_R, ST_E1_W, ST_E2_R, ST_E2_W
  } state_t;

  function automatic logic [5:0] lowest_bit(input logic [63:0] m);
    logic [5:0] idx;
    idx = '0;
    for (int j = 63; j >= 0; j--) begin
      if (m[j]) idx = 6'(j);
    end
    return idx;
  endfunction

endpackage

/* hw/rtl/min_edge_cover_blossom_core.sv */
// ----------------------------------------------------------------------------
// min_edge_cover_blossom_core
// Maximum matching (blossom search) and minimum edge cover over a stored graph.
// ----------------------------------------------------------------------------
// Add-edge transactions do a read-modify-write of two rows of the adjacency
// memory; clear zeroes every row, and a clearing pass runs after reset,
// during which no transaction is accepted. A run first resets every entry of
// the mate memory, then walks the graph through state memories that each have
// one write port and one registered read port. Results are loaded into the
// output register one at a time and wait there while the output side stalls;
// the next input is accepted once the last result of a run is loaded into the
// output register.
module min_edge_cover_blossom_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd[1:0], first_vertex[7:2], second_vertex[13:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // cover_first[5:0], cover_second[11:6],
                                  // is_isolated[12], matching_size[18:13]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mecb_pkg::state_t state_r, state_nxt;

  logic [63:0] adj_mem  [64];
  logic [6:0]  mate_mem [64];
  logic [6:0]  par_mem  [64];
  logic [5:0]  base_mem [64];
  logic [5:0]  q_mem    [64];

  logic [5:0]  adj_ra, mate_ra, par_ra, base_ra, q_ra;
  logic [63:0] adj_rd;
  logic [6:0]  mate_rd, par_rd;
  logic [5:0]  base_rd, q_rd;
  logic        adj_we, mate_we, par_we, base_we, q_we;
  logic [5:0]  adj_wa, mate_wa, par_wa, base_wa, q_wa;
  logic [63:0] adj_wd;
  logic [6:0]  mate_wd, par_wd;
  logic [5:0]  base_wd, q_wd;

  logic [6:0]  vc_r;
  logic [5:0]  clr_r;
  logic [6:0]  root_r, qh_r, qt_r, u_r, i_r, k_r, mate_v_r, mate_u_r, par_mu_r, e_r, nx_r;
  logic [5:0]  size_r;
  logic [6:0]  cnt_r;
  logic [5:0]  v_r, base_v_r, base_u_r, a_r, cb_r, x_r, child_r, bx_r, m_r, pv_r;
  logic [5:0]  ea_r, eb_r;
  logic [63:0] row_r, seen_r, vis_r, inb_r, cov_r;
  logic        mc2_r;
  logic        out_valid_r;
  logic [18:0] out_data_r;
  logic        out_last_r;

  logic [6:0]  n_c;
  logic [5:0]  u6, i6;
  logic        in_acc, cfg_wr, busy, blossom_c, emit1_c, last_c, out_load_c;
  logic [63:0] nmask_c, cand_c;
  logic [1:0]  in_cmd;
  logic [5:0]  in_first, in_second;

  assign in_cmd    = in_tdata[1:0];
  assign in_first  = in_tdata[7:2];
  assign in_second = in_tdata[13:8];
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == mecb_pkg::ADDR_VCOUNT) ? {25'd0, vc_r} : 32'd0;

  assign n_c = (vc_r == 7'd0) ? 7'd1 : ((vc_r > 7'd64) ? 7'd64 : vc_r);
  assign u6  = u_r[5:0];
  assign i6  = i_r[5:0];
  assign busy = out_valid_r && !out_tready;
  assign blossom_c = (u_r == root_r) ||
                     (mate_u_r != mecb_pkg::NONE_V && par_mu_r != mecb_pkg::NONE_V);
  assign emit1_c = (mate_rd != mecb_pkg::NONE_V) && (u_r < mate_rd);
  assign last_c  = ((cnt_r + 7'd1) == (n_c - {1'b0, size_r}));
  assign nmask_c = (n_c == 7'd64) ? {64{1'b1}} : ((64'd1 << n_c[5:0]) - 64'd1);
  assign cand_c  = adj_rd & nmask_c;
  assign out_load_c = !busy && ((state_r == mecb_pkg::ST_E1_W && emit1_c) ||
                                (state_r == mecb_pkg::ST_E2_W));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};
  assign out_tlast  = out_last_r;

  // memories
  always_ff @(posedge clk) begin
    if (adj_we)  adj_mem[adj_wa]   <= adj_wd;
    if (mate_we) mate_mem[mate_wa] <= mate_wd;
    if (par_we)  par_mem[par_wa]   <= par_wd;
    if (base_we) base_mem[base_wa] <= base_wd;
    if (q_we)    q_mem[q_wa]       <= q_wd;
    adj_rd  <= adj_mem[adj_ra];
    mate_rd <= mate_mem[mate_ra];
    par_rd  <= par_mem[par_ra];
    base_rd <= base_mem[base_ra];
    q_rd    <= q_mem[q_ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mecb_pkg::ST_CLR:      if (clr_r == 6'd63) state_nxt = mecb_pkg::ST_IDLE;
      mecb_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            mecb_pkg::CMD_ADD: if (in_first != in_second) state_nxt = mecb_pkg::ST_ADD_RA;
            mecb_pkg::CMD_RUN: state_nxt = mecb_pkg::ST_RUN_INIT;
            mecb_pkg::CMD_CLR: state_nxt = mecb_pkg::ST_CLR;
            default:           state_nxt = mecb_pkg::ST_IDLE;
          endcase
        end
      end
      mecb_pkg::ST_ADD_RA:   state_nxt = mecb_pkg::ST_ADD_WA;
      mecb_pkg::ST_ADD_WA:   state_nxt = mecb_pkg::ST_ADD_WB;
      mecb_pkg::ST_ADD_WB:   state_nxt = mecb_pkg::ST_IDLE;
      mecb_pkg::ST_RUN_INIT: if (clr_r == 6'd63) state_nxt = mecb_pkg::ST_ROOT;
      mecb_pkg::ST_ROOT:
        state_nxt = (root_r >= n_c) ? mecb_pkg::ST_E1_R : mecb_pkg::ST_ROOT_W;
      mecb_pkg::ST_ROOT_W:
        state_nxt = (mate_rd == mecb_pkg::NONE_V) ? mecb_pkg::ST_SINIT : mecb_pkg::ST_ROOT;
      mecb_pkg::ST_SINIT:    if (i_r == n_c - 7'd1) state_nxt = mecb_pkg::ST_QCHK;
      mecb_pkg::ST_QCHK:
        state_nxt = (qh_r >= qt_r) ? mecb_pkg::ST_ROOT : mecb_pkg::ST_QW;
      mecb_pkg::ST_QW:       state_nxt = mecb_pkg::ST_VW;
      mecb_pkg::ST_VW:       state_nxt = mecb_pkg::ST_UCHK;
      mecb_pkg::ST_UCHK: begin
        if (u_r >= n_c)                          state_nxt = mecb_pkg::ST_QCHK;
        else if (!row_r[u6] || mate_v_r == u_r)  state_nxt = mecb_pkg::ST_UCHK;
        else                                     state_nxt = mecb_pkg::ST_UW1;
      end
      mecb_pkg::ST_UW1:
        state_nxt = (base_rd == base_v_r) ? mecb_pkg::ST_UCHK : mecb_pkg::ST_UW2;
      mecb_pkg::ST_UW2:      state_nxt = mecb_pkg::ST_UW3;
      mecb_pkg::ST_UW3: begin
        if (blossom_c) state_nxt = mecb_pkg::ST_CBA_R;
        else if (par_rd == mecb_pkg::NONE_V && mate_u_r == mecb_pkg::NONE_V)
          state_nxt = mecb_pkg::ST_AU_R;
        else state_nxt = mecb_pkg::ST_UCHK;
      end
      mecb_pkg::ST_CBA_R:    state_nxt = mecb_pkg::ST_CBA_B;
      mecb_pkg::ST_CBA_B:    state_nxt = mecb_pkg::ST_CBA_C;
      mecb_pkg::ST_CBA_C:
        state_nxt = (mate_rd == mecb_pkg::NONE_V) ? mecb_pkg::ST_CBB_SETUP : mecb_pkg::ST_CBA_D;
      mecb_pkg::ST_CBA_D:
        state_nxt = (par_rd == mecb_pkg::NONE_V || (k_r + 7'd1) > n_c) ?
                    mecb_pkg::ST_CBB_SETUP : mecb_pkg::ST_CBA_R;
      mecb_pkg::ST_CBB_SETUP: state_nxt = mecb_pkg::ST_CBB_R;
      mecb_pkg::ST_CBB_R:    state_nxt = mecb_pkg::ST_CBB_B;
      mecb_pkg::ST_CBB_B:
        state_nxt = seen_r[base_rd] ? mecb_pkg::ST_MC_SETUP : mecb_pkg::ST_CBB_C;
      mecb_pkg::ST_CBB_C:
        state_nxt = (mate_rd == mecb_pkg::NONE_V) ? mecb_pkg::ST_MC_SETUP : mecb_pkg::ST_CBB_D;
      mecb_pkg::ST_CBB_D:
        state_nxt = (par_rd == mecb_pkg::NONE_V || (k_r + 7'd1) > n_c) ?
                    mecb_pkg::ST_MC_SETUP : mecb_pkg::ST_CBB_R;
      mecb_pkg::ST_MC_SETUP: state_nxt = mecb_pkg::ST_MC_R;
      mecb_pkg::ST_MC_R:
        state_nxt = (k_r > n_c) ? mecb_pkg::ST_MC_NEXT : mecb_pkg::ST_MC_B;
      mecb_pkg::ST_MC_B:
        state_nxt = (base_rd == cb_r) ? mecb_pkg::ST_MC_NEXT : mecb_pkg::ST_MC_C;
      mecb_pkg::ST_MC_C:
        state_nxt = (mate_rd == mecb_pkg::NONE_V) ? mecb_pkg::ST_MC_NEXT : mecb_pkg::ST_MC_D;
      mecb_pkg::ST_MC_D:     state_nxt = mecb_pkg::ST_MC_E;
      mecb_pkg::ST_MC_E:
        state_nxt = (par_rd == mecb_pkg::NONE_V) ? mecb_pkg::ST_MC_NEXT : mecb_pkg::ST_MC_R;
      mecb_pkg::ST_MC_NEXT:  state_nxt = mc2_r ? mecb_pkg::ST_CT_R : mecb_pkg::ST_MC_R;
      mecb_pkg::ST_CT_R:
        state_nxt = (i_r >= n_c) ? mecb_pkg::ST_UCHK : mecb_pkg::ST_CT_B;
      mecb_pkg::ST_CT_B:     state_nxt = mecb_pkg::ST_CT_R;
      mecb_pkg::ST_AU_R:
        state_nxt = (k_r > n_c || e_r == mecb_pkg::NONE_V) ?
                    mecb_pkg::ST_AU_END : mecb_pkg::ST_AU_B;
      mecb_pkg::ST_AU_B:
        state_nxt = (par_rd == mecb_pkg::NONE_V) ? mecb_pkg::ST_AU_END : mecb_pkg::ST_AU_C;
      mecb_pkg::ST_AU_C:     state_nxt = mecb_pkg::ST_AU_D;
      mecb_pkg::ST_AU_D:     state_nxt = mecb_pkg::ST_AU_R;
      mecb_pkg::ST_AU_END:   state_nxt = mecb_pkg::ST_ROOT;
      mecb_pkg::ST_E1_R:
        state_nxt = (u_r >= n_c) ? mecb_pkg::ST_E2_R : mecb_pkg::ST_E1_W;
      mecb_pkg::ST_E1_W:
        state_nxt = (emit1_c && busy) ? mecb_pkg::ST_E1_W : mecb_pkg::ST_E1_R;
      mecb_pkg::ST_E2_R: begin
        if (u_r >= n_c)      state_nxt = mecb_pkg::ST_IDLE;
        else if (cov_r[u6])  state_nxt = mecb_pkg::ST_E2_R;
        else                 state_nxt = mecb_pkg::ST_E2_W;
      end
      mecb_pkg::ST_E2_W:     state_nxt = busy ? mecb_pkg::ST_E2_W : mecb_pkg::ST_E2_R;
      default:               state_nxt = mecb_pkg::ST_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    adj_ra = '0; mate_ra = '0; par_ra = '0; base_ra = '0; q_ra = '0;
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0;
    mate_we = 1'b0; mate_wa = '0; mate_wd = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0;
    base_we = 1'b0; base_wa = '0; base_wd = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0;
    in_tready = (state_r == mecb_pkg::ST_IDLE);
    unique case (state_r)
      mecb_pkg::ST_CLR: begin
        adj_we = 1'b1; adj_wa = clr_r;
      end
      mecb_pkg::ST_ADD_RA: adj_ra = ea_r;
      mecb_pkg::ST_ADD_WA: begin
        adj_we = 1'b1; adj_wa = ea_r; adj_wd = adj_rd | (64'd1 << eb_r);
        adj_ra = eb_r;
      end
      mecb_pkg::ST_ADD_WB: begin
        adj_we = 1'b1; adj_wa = eb_r; adj_wd = adj_rd | (64'd1 << ea_r);
      end
      mecb_pkg::ST_RUN_INIT: begin
        mate_we = 1'b1; mate_wa = clr_r; mate_wd = mecb_pkg::NONE_V;
      end
      mecb_pkg::ST_ROOT: mate_ra = root_r[5:0];
      mecb_pkg::ST_SINIT: begin
        par_we = 1'b1; par_wa = i6; par_wd = mecb_pkg::NONE_V;
        base_we = 1'b1; base_wa = i6; base_wd = i6;
        q_we = (i_r == n_c - 7'd1); q_wa = '0; q_wd = root_r[5:0];
      end
      mecb_pkg::ST_QCHK: q_ra = qh_r[5:0];
      mecb_pkg::ST_QW: begin
        adj_ra = q_rd; mate_ra = q_rd; base_ra = q_rd;
      end
      mecb_pkg::ST_UCHK: begin
        base_ra = u6; mate_ra = u6;
      end
      mecb_pkg::ST_UW1: par_ra = mate_rd[5:0];
      mecb_pkg::ST_UW2: par_ra = u6;
      mecb_pkg::ST_UW3: begin
        if (!blossom_c && par_rd == mecb_pkg::NONE_V) begin
          par_we = 1'b1; par_wa = u6; par_wd = {1'b0, v_r};
          if (mate_u_r != mecb_pkg::NONE_V && qt_r < 7'd64) begin
            q_we = 1'b1; q_wa = qt_r[5:0]; q_wd = mate_u_r[5:0];
          end
        end
      end
      mecb_pkg::ST_CBA_R, mecb_pkg::ST_CBB_R: base_ra = a_r;
      mecb_pkg::ST_CBA_B, mecb_pkg::ST_CBB_B: mate_ra = base_rd;
      mecb_pkg::ST_CBA_C, mecb_pkg::ST_CBB_C: par_ra = mate_rd[5:0];
      mecb_pkg::ST_MC_R: base_ra = x_r;
      mecb_pkg::ST_MC_B: mate_ra = x_r;
      mecb_pkg::ST_MC_C: begin
        if (mate_rd != mecb_pkg::NONE_V) begin
          par_we = 1'b1; par_wa = x_r; par_wd = {1'b0, child_r};
        end
        base_ra = mate_rd[5:0];
      end
      mecb_pkg::ST_MC_D: par_ra = m_r;
      mecb_pkg::ST_CT_R: base_ra = i6;
      mecb_pkg::ST_CT_B: begin
        if (inb_r[base_rd]) begin
          base_we = 1'b1; base_wa = i6; base_wd = cb_r;
          if (!vis_r[i6] && qt_r < 7'd64) begin
            q_we = 1'b1; q_wa = qt_r[5:0]; q_wd = i6;
          end
        end
      end
      mecb_pkg::ST_AU_R: par_ra = e_r[5:0];
      mecb_pkg::ST_AU_B: mate_ra = par_rd[5:0];
      mecb_pkg::ST_AU_C: begin
        mate_we = 1'b1; mate_wa = e_r[5:0]; mate_wd = {1'b0, pv_r};
      end
      mecb_pkg::ST_AU_D: begin
        mate_we = 1'b1; mate_wa = pv_r; mate_wd = e_r;
      end
      mecb_pkg::ST_E1_R, mecb_pkg::ST_E1_W: mate_ra = u6;
      mecb_pkg::ST_E2_R, mecb_pkg::ST_E2_W: adj_ra = u6;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mecb_pkg::ST_CLR;
      clr_r       <= '0;
      vc_r        <= mecb_pkg::VC_RESET;
      out_valid_r <= 1'b0;
      qh_r        <= '0;
      qt_r        <= '0;
      size_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr == mecb_pkg::ADDR_VCOUNT) vc_r <= cfg_pwdata[6:0];
      if (out_load_c)      out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        mecb_pkg::ST_IDLE: begin
          if (in_acc) begin
            ea_r <= in_first; eb_r <= in_second; clr_r <= '0;
          end
        end
        mecb_pkg::ST_CLR: clr_r <= clr_r + 6'd1;
        mecb_pkg::ST_RUN_INIT: begin
          clr_r <= clr_r + 6'd1;
          if (clr_r == 6'd63) begin
            root_r <= '0; size_r <= '0;
          end
        end
        mecb_pkg::ST_ROOT: begin
          if (root_r >= n_c) begin
            u_r <= '0; cov_r <= '0; cnt_r <= '0;
          end
        end
        mecb_pkg::ST_ROOT_W: begin
          if (mate_rd != mecb_pkg::NONE_V) root_r <= root_r + 7'd1;
          else begin
            i_r <= '0; vis_r <= '0;
          end
        end
        mecb_pkg::ST_SINIT: begin
          i_r <= i_r + 7'd1;
          if (i_r == n_c - 7'd1) begin
            qh_r <= '0; qt_r <= 7'd1; vis_r[root_r[5:0]] <= 1'b1;
          end
        end
        mecb_pkg::ST_QCHK: if (qh_r >= qt_r) root_r <= root_r + 7'd1;
        mecb_pkg::ST_QW: begin
          v_r <= q_rd; qh_r <= qh_r + 7'd1;
        end
        mecb_pkg::ST_VW: begin
          row_r <= adj_rd; mate_v_r <= mate_rd; base_v_r <= base_rd; u_r <= '0;
        end
        mecb_pkg::ST_UCHK: begin
          if (u_r < n_c && (!row_r[u6] || mate_v_r == u_r)) u_r <= u_r + 7'd1;
        end
        mecb_pkg::ST_UW1: begin
          base_u_r <= base_rd; mate_u_r <= mate_rd;
          if (base_rd == base_v_r) u_r <= u_r + 7'd1;
        end
        mecb_pkg::ST_UW2: par_mu_r <= par_rd;
        mecb_pkg::ST_UW3: begin
          if (blossom_c) begin
            a_r <= v_r; k_r <= '0; seen_r <= '0;
          end else if (par_rd == mecb_pkg::NONE_V) begin
            if (mate_u_r == mecb_pkg::NONE_V) begin
              e_r <= u_r; k_r <= '0;
            end else begin
              vis_r[mate_u_r[5:0]] <= 1'b1;
              if (qt_r < 7'd64) qt_r <= qt_r + 7'd1;
              u_r <= u_r + 7'd1;
            end
          end else begin
            u_r <= u_r + 7'd1;
          end
        end
        mecb_pkg::ST_CBA_B: begin
          a_r <= base_rd; seen_r[base_rd] <= 1'b1;
        end
        mecb_pkg::ST_CBA_D, mecb_pkg::ST_CBB_D: begin
          if (par_rd != mecb_pkg::NONE_V) begin
            a_r <= par_rd[5:0]; k_r <= k_r + 7'd1;
          end
        end
        mecb_pkg::ST_CBB_SETUP: begin
          a_r <= u6; k_r <= '0;
        end
        mecb_pkg::ST_CBB_B: a_r <= base_rd;
        mecb_pkg::ST_MC_SETUP: begin
          cb_r <= a_r; inb_r <= '0; x_r <= v_r; child_r <= u6; k_r <= '0; mc2_r <= 1'b0;
        end
        mecb_pkg::ST_MC_B: bx_r <= base_rd;
        mecb_pkg::ST_MC_C: begin
          if (mate_rd != mecb_pkg::NONE_V) begin
            inb_r[bx_r] <= 1'b1; child_r <= mate_rd[5:0]; m_r <= mate_rd[5:0];
          end
        end
        mecb_pkg::ST_MC_D: inb_r[base_rd] <= 1'b1;
        mecb_pkg::ST_MC_E: begin
          if (par_rd != mecb_pkg::NONE_V) begin
            x_r <= par_rd[5:0]; k_r <= k_r + 7'd1;
          end
        end
        mecb_pkg::ST_MC_NEXT: begin
          if (!mc2_r) begin
            mc2_r <= 1'b1; x_r <= u6; child_r <= v_r; k_r <= '0;
          end else begin
            i_r <= '0;
          end
        end
        mecb_pkg::ST_CT_R: begin
          if (i_r >= n_c) begin
            if (inb_r[base_v_r]) base_v_r <= cb_r;
            u_r <= u_r + 7'd1;
          end
        end
        mecb_pkg::ST_CT_B: begin
          if (inb_r[base_rd] && !vis_r[i6]) begin
            vis_r[i6] <= 1'b1;
            if (qt_r < 7'd64) qt_r <= qt_r + 7'd1;
          end
          i_r <= i_r + 7'd1;
        end
        mecb_pkg::ST_AU_B: pv_r <= par_rd[5:0];
        mecb_pkg::ST_AU_C: nx_r <= mate_rd;
        mecb_pkg::ST_AU_D: begin
          e_r <= nx_r; k_r <= k_r + 7'd1;
        end
        mecb_pkg::ST_AU_END: begin
          size_r <= size_r + 6'd1; root_r <= root_r + 7'd1;
        end
        mecb_pkg::ST_E1_R: if (u_r >= n_c) u_r <= '0;
        mecb_pkg::ST_E1_W: begin
          if (!emit1_c) u_r <= u_r + 7'd1;
          else if (!busy) begin
            out_data_r  <= {size_r, 1'b0, mate_rd[5:0], u6};
            out_last_r  <= last_c;
            cov_r[u6] <= 1'b1; cov_r[mate_rd[5:0]] <= 1'b1;
            cnt_r <= cnt_r + 7'd1; u_r <= u_r + 7'd1;
          end
        end
        mecb_pkg::ST_E2_R: if (u_r < n_c && cov_r[u6]) u_r <= u_r + 7'd1;
        mecb_pkg::ST_E2_W: begin
          if (!busy) begin
            if (cand_c != 64'd0)
              out_data_r <= {size_r, 1'b0, mecb_pkg::lowest_bit(cand_c), u6};
            else
              out_data_r <= {size_r, 1'b1, u6, u6};
            out_last_r <= last_c;
            cnt_r <= cnt_r + 7'd1; u_r <= u_r + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (qh_r <= qt_r) && (qt_r <= 7'd64))
    else $error("queue head passed tail");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= 6'd32)
    else $error("matching size out of range");

  a_distinct_bases: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mecb_pkg::ST_UW3) |-> (base_u_r != base_v_r))
    else $error("edge inside one blossom reached the tree step");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result overwritten before transaction");

endmodule
